// ----- hdl/random_fourier_feature_map_assert.svh -----
// Assertion macros used by the port checker file.
`ifndef RANDOM_FOURIER_FEATURE_MAP_ASSERT_SVH
`define RANDOM_FOURIER_FEATURE_MAP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RFF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define RFF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/rff_pkg.sv -----
// Package for the random Fourier feature map: types, constants, cosine table.
`default_nettype none
package rff_pkg;
  localparam int unsigned MaxInDef   = 16;
  localparam int unsigned MaxOutDef  = 64;
  localparam int unsigned CosBitsDef = 10;
  localparam int unsigned PhaseBits  = 24;

  localparam logic [1:0] ReqWeight = 2'd0;
  localparam logic [1:0] ReqBias   = 2'd1;
  localparam logic [1:0] ReqElem   = 2'd2;

  localparam logic [1:0] CfgInSize   = 2'd0;
  localparam logic [1:0] CfgOutSize  = 2'd1;
  localparam logic [1:0] CfgOutScale = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] data_value;
    logic               last_element;
  } rff_req_t;

  typedef struct packed {
    logic signed [15:0] feature_value;
    logic [5:0]         feature_index;
    logic               last_feature;
  } rff_res_t;

  // Quarter-turn cosine in Q1.15 by the Horner series (elaboration only).
  // Every product stays non-negative, so the Q30 shift then the small
  // divide truncates exactly like one divide by den * 2^30.
  function automatic longint quarter_cos(input longint u, input int unsigned bits);
    longint theta;
    longint x2;
    longint h;
    theta = (u * 64'sd6746518852) >>> bits;
    x2 = (theta * theta) >>> 30;
    h = 64'sd1 <<< 30;
    h = (64'sd1 <<< 30) - ((x2 * h) >>> 30) / 132;
    h = (64'sd1 <<< 30) - ((x2 * h) >>> 30) / 90;
    h = (64'sd1 <<< 30) - ((x2 * h) >>> 30) / 56;
    h = (64'sd1 <<< 30) - ((x2 * h) >>> 30) / 30;
    h = (64'sd1 <<< 30) - ((x2 * h) >>> 30) / 12;
    h = (64'sd1 <<< 30) - ((x2 * h) >>> 31);
    if (h < 0) h = 0;
    if (h > (64'sd1 <<< 30)) h = 64'sd1 <<< 30;
    h = (h + 64'sd16384) >>> 15;
    if (h > 32767) h = 32767;
    return h;
  endfunction

  // Full-turn cosine table entry k of 2^bits.
  function automatic logic signed [15:0] cos_entry(input longint k, input int unsigned bits);
    longint n;
    longint q;
    longint v;
    n = 64'sd1 <<< bits;
    q = n >>> 2;
    if (k <= q) v = quarter_cos(k, bits);
    else if (k <= 2 * q) v = -quarter_cos(2 * q - k, bits);
    else if (k < 3 * q) v = -quarter_cos(k - 2 * q, bits);
    else v = quarter_cos(n - k, bits);
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

// ----- hdl/random_fourier_feature_map.sv -----
// Top level of the random Fourier feature map.
// Usage: one command channel (start/busy, req_i) carries weight writes,
// bias writes and input elements. The element marked last starts the
// feature computation: for each of out_size rows (capped at MAX_OUT) the
// shared multiplier walks in_size columns (capped at MAX_IN), one product
// per cycle; a zero in_size still passes through the multiply state. A
// drain state, the cosine table and the scale multiplier follow, then the
// beat is emitted. The final beat shows in the cycle in which busy falls.
// A zero out_size starts nothing.
// Each result shows on res_o for one cycle with res_valid_o; the receiver
// cannot stall. Configuration is to go through cfg_we_i/cfg_idx_i/cfg_data_i
// only while idle; the block itself does not enforce this. Reset clears the
// sequencer and loads in_size 16, out_size 64, out_scale 4096; weight, bias
// and input stores are undefined until written.
`default_nettype none
module random_fourier_feature_map #(
  parameter int unsigned MAX_IN         = rff_pkg::MaxInDef,
  parameter int unsigned MAX_OUT        = rff_pkg::MaxOutDef,
  parameter int unsigned COS_TABLE_BITS = rff_pkg::CosBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rff_pkg::rff_req_t req_i,
  output logic                  res_valid_o,
  output rff_pkg::rff_res_t     res_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [14:0]      cfg_data_i
);
  import rff_pkg::*;

  localparam int unsigned InW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int unsigned OutW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int unsigned WDep  = MAX_IN * MAX_OUT;
  localparam int unsigned WAw   = (WDep > 1) ? $clog2(WDep) : 1;
  localparam int unsigned NCos  = 1 << COS_TABLE_BITS;
  localparam int unsigned RndSh = PhaseBits - COS_TABLE_BITS;

  typedef enum logic [2:0] {
    StIdle, StMac, StDrain, StPhase, StScale, StEmit
  } state_e;

  // stores
  logic signed [15:0] wmem [WDep];
  logic [15:0]        bmem [MAX_OUT];
  logic signed [15:0] xbuf [MAX_IN];
  logic signed [15:0] w_rd_q;
  logic signed [15:0] x_rd_q;
  logic [15:0]        b_rd_q;

  logic [4:0]  in_size_q;
  logic [6:0]  out_size_q;
  logic [14:0] out_scale_q;
  logic [4:0]  elem_cnt_q;

  state_e      state_q;
  logic [6:0]  ni_q, no_q;
  logic [6:0]  row_q;
  logic [6:0]  col_q;
  logic [2:0]  drain_q;
  logic        rd_en_q;
  logic signed [15:0] cos_q;
  logic [30:0] scaled_q;
  logic        neg_q;

  logic        acc_clr;
  logic        rd_en;
  logic [23:0] acc;
  logic [WAw-1:0] rd_addr;
  logic [23:0] phase;
  logic [COS_TABLE_BITS-1:0] k;
  logic signed [15:0] cos_tab [NCos];
  logic [15:0] mag;

  // constant cosine table
  for (genvar g = 0; g < NCos; g++) begin : g_cos
    assign cos_tab[g] = cos_entry(longint'(g), COS_TABLE_BITS);
  end

  assign busy = (state_q != StIdle);
  wire accept = start && !busy;

  // store writes
  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == ReqWeight &&
        32'(req_i.row_index) < MAX_OUT && 32'(req_i.col_index) < MAX_IN) begin
      wmem[WAw'(32'(req_i.row_index) * MAX_IN + 32'(req_i.col_index))] <= req_i.data_value;
    end
    if (accept && req_i.req_type == ReqBias && 32'(req_i.row_index) < MAX_OUT) begin
      bmem[OutW'(req_i.row_index)] <= req_i.data_value;
    end
    if (accept && req_i.req_type == ReqElem && 32'(req_i.col_index) < MAX_IN) begin
      xbuf[InW'(req_i.col_index)] <= req_i.data_value;
    end
    w_rd_q <= wmem[rd_addr];
    x_rd_q <= xbuf[InW'(col_q)];
    b_rd_q <= bmem[OutW'(row_q)];
  end

  assign rd_addr = WAw'(32'(row_q) * MAX_IN + 32'(col_q));
  // no products at all when no column is in use
  assign rd_en   = (state_q == StMac) && (ni_q != '0);
  assign acc_clr = (state_q == StIdle) || (state_q == StEmit);

  rff_mac u_mac (
    .clk_i (clk_i),
    .clr_i (acc_clr),
    .en_i  (rd_en_q),
    .a_i   (w_rd_q),
    .b_i   (x_rd_q),
    .acc_o (acc)
  );

  assign phase = acc + {b_rd_q, 8'd0};
  assign k     = COS_TABLE_BITS'((25'(phase) + 25'(1 << (RndSh - 1))) >> RndSh);
  assign mag   = cos_q[15] ? 16'(-cos_q) : 16'(cos_q);

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_size_q   <= 5'd16;
      out_size_q  <= 7'd64;
      out_scale_q <= 15'd4096;
      elem_cnt_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      ni_q        <= '0;
      no_q        <= '0;
      drain_q     <= '0;
      rd_en_q     <= 1'b0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
      cos_q       <= '0;
      scaled_q    <= '0;
      neg_q       <= 1'b0;
    end else begin
      rd_en_q     <= rd_en;
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgInSize:   in_size_q   <= cfg_data_i[4:0];
          CfgOutSize:  out_size_q  <= cfg_data_i[6:0];
          CfgOutScale: out_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          row_q <= '0;
          col_q <= '0;
          if (accept && req_i.req_type == ReqElem) begin
            if (elem_cnt_q != 5'd31) elem_cnt_q <= elem_cnt_q + 5'd1;
            if (req_i.last_element) begin
              elem_cnt_q <= '0;
              ni_q <= (32'(in_size_q) > MAX_IN) ? 7'(MAX_IN) : 7'(in_size_q);
              no_q <= (32'(out_size_q) > MAX_OUT) ? 7'(MAX_OUT) : out_size_q;
              if (out_size_q != '0) state_q <= StMac;
            end
          end
        end
        StMac: begin
          if (col_q + 7'd1 >= ni_q || ni_q == '0) begin
            state_q <= StDrain;
            drain_q <= '0;
          end else begin
            col_q <= col_q + 7'd1;
          end
        end
        StDrain: begin
          drain_q <= drain_q + 3'd1;
          if (drain_q == 3'd2) state_q <= StPhase;
        end
        StPhase: begin
          cos_q   <= cos_tab[k];
          state_q <= StScale;
        end
        StScale: begin
          scaled_q <= 31'(mag) * 31'(out_scale_q) + 31'd16384;
          neg_q    <= cos_q[15];
          state_q  <= StEmit;
        end
        StEmit: begin
          res_valid_o         <= 1'b1;
          res_o.feature_value <= neg_q ? -16'(scaled_q[30:15]) : 16'(scaled_q[30:15]);
          res_o.feature_index <= 6'(row_q);
          res_o.last_feature  <= (row_q + 7'd1 == no_q);
          col_q <= '0;
          if (row_q + 7'd1 == no_q) begin
            state_q <= StIdle;
          end else begin
            row_q   <= row_q + 7'd1;
            state_q <= StMac;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/rff_mac.sv -----
// Shared multiply-accumulate unit: one registered product, one accumulator.
`default_nettype none
module rff_mac (
  input  wire logic               clk_i,
  input  wire logic               clr_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] a_i,
  input  wire logic signed [15:0] b_i,
  output logic [23:0]             acc_o
);
  logic signed [31:0] prod_q;
  logic [23:0]        acc_q;
  logic               pv_q;

  // product register, then add into the low 24 phase bits
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    pv_q   <= en_i;
    if (clr_i) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + prod_q[23:0];
    end
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

// ----- hdl/rff_checker.sv -----
// Port-level checker for the random Fourier feature map, bound to the top.
`default_nettype none
`include "random_fourier_feature_map_assert.svh"
module rff_port_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              res_valid_o,
  input wire rff_pkg::rff_res_t res_o
);
  import rff_pkg::*;
  // results come only during a computation
  `RFF_ASSERT_IMP(a_res_busy, clk_i, rst_ni, res_valid_o, $past(busy))
  // the final feature ends the computation
  `RFF_ASSERT_IMP(a_last_idle, clk_i, rst_ni, res_valid_o && res_o.last_feature, !busy)
  // results are isolated single-cycle strobes
  `RFF_ASSERT_NXT(a_strobe, clk_i, rst_ni, res_valid_o, !res_valid_o)
  // a computation only starts from a taken command beat
  `RFF_ASSERT_IMP(a_busy_cause, clk_i, rst_ni, $rose(busy), $past(start))
endmodule

bind random_fourier_feature_map rff_port_checker u_rff_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire

// ----- tb/sv/rff_checker.sv -----
// Checker for the random Fourier feature map: predicts feature beats and compares them.
`timescale 1ns / 1ps
module rff_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  rff_pkg::rff_req_t req_i,
  input  logic              res_valid_o,
  input  rff_pkg::rff_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [14:0]       cfg_data_i,
  output int                fail_count,
  output int                pending
);
  import rff_pkg::*;

  localparam longint QOne = 64'sd1 <<< 30;

  // Local copy of the stores and the registers
  logic signed [15:0] weight_mem [MaxOutDef * MaxInDef];
  logic [15:0]        bias_mem   [MaxOutDef];
  logic signed [15:0] elem_mem   [MaxInDef];
  logic [4:0]         n_in;
  logic [6:0]         n_out;
  logic [14:0]        scale;
  rff_res_t           feature_q [$];

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // First-quadrant cosine, Q1.15, by truncating Horner series
  function automatic longint quarter_wave(input longint u);
    longint th;
    longint sq;
    longint h;
    longint den [6];
    den = '{132, 90, 56, 30, 12, 2};
    th = (u * 64'sd6746518852) / (64'sd1 <<< CosBitsDef);
    sq = (th * th) / QOne;
    h = QOne;
    for (int i = 0; i < 6; i++) h = QOne - (sq * h) / (den[i] * QOne);
    if (h < 0) h = 0;
    if (h > QOne) h = QOne;
    h = (h + 16384) / 32768;
    if (h > 32767) h = 32767;
    return h;
  endfunction

  // Full-turn cosine at table slot k, folded by quadrant
  function automatic longint turn_cos(input longint k);
    longint n;
    longint q;
    n = 64'sd1 <<< CosBitsDef;
    q = n / 4;
    if (k <= q) return quarter_wave(k);
    else if (k <= 2 * q) return -quarter_wave(2 * q - k);
    else if (k < 3 * q) return -quarter_wave(k - 2 * q);
    return quarter_wave(n - k);
  endfunction

  // Queue one feature beat per active row
  task automatic predict_features();
    int     ni;
    int     no;
    longint acc;
    longint cv;
    longint mag;
    longint feat;
    logic [63:0] ph;
    logic [63:0] k;
    rff_res_t f;
    ni = (n_in > MaxInDef) ? MaxInDef : n_in;
    no = (n_out > MaxOutDef) ? MaxOutDef : n_out;
    for (int r = 0; r < no; r++) begin
      acc = 0;
      for (int c = 0; c < ni; c++)
        acc += longint'(weight_mem[r * MaxInDef + c]) * longint'(elem_mem[c]);
      ph = (acc + (longint'(bias_mem[r]) <<< 8)) & 64'hFF_FFFF;
      k = ((ph + (64'd1 << (PhaseBits - CosBitsDef - 1))) >> (PhaseBits - CosBitsDef))
          & ((64'd1 << CosBitsDef) - 1);
      cv = turn_cos(longint'(k));
      mag = (cv < 0) ? -cv : cv;
      mag = (mag * longint'(scale) + 16384) / 32768;
      feat = (cv < 0) ? -mag : mag;
      f.feature_value = feat[15:0];
      f.feature_index = r[5:0];
      f.last_feature  = (r + 1 == no);
      feature_q.push_back(f);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rff_res_t e;
    if (!rst_ni) begin
      n_in  = 5'd16;
      n_out = 7'd64;
      scale = 15'd4096;
      fail_count = 0;
      feature_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgInSize:   n_in  = cfg_data_i[4:0];
          CfgOutSize:  n_out = cfg_data_i[6:0];
          CfgOutScale: scale = cfg_data_i;
          default: ;
        endcase
      end
      // output beat check
      if (res_valid_o) begin
        if (feature_q.size() == 0) begin
          report($sformatf("unexpected feature beat row %0d", res_o.feature_index));
        end else begin
          e = feature_q.pop_front();
          if (res_o.feature_value !== e.feature_value)
            report($sformatf("row %0d value %0d, want %0d", e.feature_index,
                             res_o.feature_value, e.feature_value));
          if (res_o.feature_index !== e.feature_index)
            report($sformatf("index %0d, want %0d", res_o.feature_index, e.feature_index));
          if (res_o.last_feature !== e.last_feature)
            report($sformatf("row %0d last flag %0b, want %0b", e.feature_index,
                             res_o.last_feature, e.last_feature));
        end
      end
      // accepted command beat
      if (start && !busy) begin
        case (req_i.req_type)
          ReqWeight: weight_mem[req_i.row_index * MaxInDef + req_i.col_index] = req_i.data_value;
          ReqBias:   bias_mem[req_i.row_index] = req_i.data_value;
          ReqElem: begin
            elem_mem[req_i.col_index] = req_i.data_value;
            if (req_i.last_element) predict_features();
          end
          default: ;
        endcase
      end
    end
    pending = feature_q.size();
  end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the random Fourier feature map: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import rff_pkg::*;

  localparam logic [1:0] ReqIgnored = 2'd3;
  localparam int QuietLimit = 3000;
  // Store region that is filled up front; computations stay inside it
  localparam int FillRows = 4;
  localparam int FillCols = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  rff_req_t    req_i = '0;
  logic        res_valid_o;
  rff_res_t    res_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgInSize;
  logic [14:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          quiet = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  random_fourier_feature_map uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  rff_checker u_check (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count, .pending
  );

  // Watchdog: cycles with neither a command nor a feature beat
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one command beat and hold it until taken
  task automatic send(input logic [1:0] rt, input logic [5:0] row, input logic [3:0] col,
                      input logic [15:0] data, input logic last);
    rff_req_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= rff_req_t'($urandom);
      @(posedge clk_i);
    end
    r.req_type     = rt;
    r.row_index    = row;
    r.col_index    = col;
    r.data_value   = data;
    r.last_element = last;
    start <= 1'b1;
    req_i <= r;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Drain all expected features, then let the sequencer finish
  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [14:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [14:0] ni, input logic [14:0] no,
                           input logic [14:0] sc);
    write_cfg(CfgInSize, ni);
    write_cfg(CfgOutSize, no);
    write_cfg(CfgOutScale, sc);
    cfg_we_i <= 1'b0;
  endtask

  // Random commands: nearly half element writes, the rest table updates and noise
  task automatic random_items(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send(ReqElem, 6'($urandom), 4'($urandom), 16'($urandom), $urandom_range(3) == 0);
      else if (pick < 70)
        send(ReqWeight, 6'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
      else if (pick < 90)
        send(ReqBias, 6'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
      else
        send(ReqIgnored, 6'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
    end
    send(ReqElem, 6'($urandom), 4'($urandom), 16'($urandom), 1'b1);
    settle();
  endtask

  initial begin
    int idle_modes [3];
    idle_modes = '{0, 74, 37};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the used store region so no computation reads an unwritten entry
    for (int r = 0; r < FillRows; r++) begin
      for (int c = 0; c < FillCols; c++) send(ReqWeight, 6'(r), 4'(c), 16'($urandom), 1'b0);
      send(ReqBias, 6'(r), 4'd0, 16'($urandom), 1'b0);
    end
    for (int c = 0; c < FillCols; c++) send(ReqElem, 6'd0, 4'(c), 16'($urandom), 1'b0);
    settle();

    // Directed: field extremes, ignored flags and requests, size corners
    set_sizes(15'(FillCols), 15'(FillRows), 15'd4096);
    send(ReqWeight, 6'd63, 4'd15, 16'h8000, 1'b0);
    send(ReqWeight, 6'd0, 4'd0, 16'h7FFF, 1'b0);
    send(ReqBias, 6'd0, 4'd0, 16'hFFFF, 1'b0);
    send(ReqBias, 6'd63, 4'd15, 16'h0000, 1'b1);
    send(ReqWeight, 6'd1, 4'd1, 16'h0000, 1'b1);
    send(ReqIgnored, 6'd2, 4'd2, 16'h1234, 1'b1);
    send(ReqElem, 6'd0, 4'd0, 16'h7FFF, 1'b0);
    send(ReqElem, 6'd63, 4'd15, 16'h8000, 1'b0);
    send(ReqElem, 6'd0, 4'd1, 16'h0000, 1'b1);
    settle();
    set_sizes(15'd1, 15'd1, 15'd32767);
    send(ReqElem, 6'd0, 4'd0, 16'hFFFF, 1'b1);
    settle();
    set_sizes(15'(FillCols), 15'(FillRows), 15'd0);
    send(ReqElem, 6'd5, 4'd3, 16'h4000, 1'b1);
    settle();
    // out_size zero emits nothing; in_size zero leaves the bias alone
    set_sizes(15'd0, 15'd0, 15'd32767);
    send(ReqElem, 6'd0, 4'd2, 16'h0001, 1'b1);
    settle();
    set_sizes(15'd0, 15'd3, 15'd16384);
    send(ReqElem, 6'd0, 4'd2, 16'h0001, 1'b1);
    settle();

    // Random phases with varied sizes and idling
    for (int p = 0; p < 6; p++) begin
      idle_pct = idle_modes[p % 3];
      if (p == 5) set_sizes(15'(FillCols), 15'(FillRows), 15'($urandom_range(32767)));
      else set_sizes(15'($urandom_range(1, FillCols)), 15'($urandom_range(1, FillRows)),
                     15'($urandom_range(32767)));
      random_items(7);
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
